// File: rtl/core/iepm_pkg.sv
// package for the paged eeprom i2c master: types, codes and constants
`timescale 1ns / 1ps

package iepm_pkg;

    localparam int PAGE_BYTES = 128;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_TWO_BYTE  = 2'd0;
    localparam logic [1:0] REG_ACK_TIME  = 2'd1;
    localparam logic [1:0] REG_PAGE_WAIT = 2'd2;

    localparam logic [7:0] DEV_WRITE = 8'hA0;
    localparam logic [7:0] DEV_READ  = 8'hA1;

    // word entering the queue between front and back
    typedef struct packed {
        logic        is_tick;
        logic        is_read;
        logic [15:0] address;
        logic [7:0]  data;
        logic        final_byte;
        logic        sda;
    } iepm_item_t;

    // configuration shared with the engine
    typedef struct packed {
        logic        two_byte;
        logic [7:0]  ack_ticks;
        logic [23:0] page_ticks;
    } iepm_cfg_t;

    // one bus tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       byte_done;
        logic       no_ack_error;
        logic       engine_busy;
    } iepm_res_t;

endpackage

// File: rtl/core/iepm_front.sv
// front part: config registers, command decode and a two-entry word queue
`timescale 1ns / 1ps

module iepm_front
    import iepm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output iepm_cfg_t   cfg,
    output logic        q_valid,
    input  logic        q_ready,
    output iepm_item_t  q_item
);

    iepm_cfg_t  cfg_reg;
    iepm_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;
    logic [1:0] cmd;
    iepm_item_t item;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.two_byte   <= 1'b1;
            cfg_reg.ack_ticks  <= 8'd250;
            cfg_reg.page_ticks <= 24'd10000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TWO_BYTE:  cfg_reg.two_byte   <= cfg_data[0];
                REG_ACK_TIME:  cfg_reg.ack_ticks  <= cfg_data[7:0];
                REG_PAGE_WAIT: cfg_reg.page_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify: unknown commands are dropped here
    assign cmd             = s_axis_tuser;
    assign item.is_tick    = (cmd == CMD_TICK);
    assign item.is_read    = (cmd == CMD_READ);
    assign item.address    = s_axis_tdata[15:0];
    assign item.data       = s_axis_tdata[23:16];
    assign item.final_byte = s_axis_tlast;
    assign item.sda        = s_axis_tdata[24];

    assign s_axis_tready = (count_reg != 2'd2);
    assign push = s_axis_tvalid && s_axis_tready && (cmd != CMD_UNKNOWN);
    assign pop  = q_valid && q_ready;

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/core/iepm_engine.sv
// back part: bus phase engine with an output register stage
`timescale 1ns / 1ps

module iepm_engine
    import iepm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  iepm_cfg_t  cfg,
    input  logic       q_valid,
    output logic       q_ready,
    input  iepm_item_t q_item,
    output logic       res_valid,
    input  logic       res_ready,
    output iepm_res_t  res
);

    localparam logic [4:0] P_IDLE = 5'd0, P_ST_FALL = 5'd1, P_ST_LOW = 5'd2,
        P_RS_PREP = 5'd3, P_RS_HIGH = 5'd4, P_TX_SETUP = 5'd5, P_TX_HIGH = 5'd6,
        P_ACK_SETUP = 5'd7, P_ACK_HIGH = 5'd8, P_RX_LOW = 5'd9, P_RX_HIGH = 5'd10,
        P_MA_SETUP = 5'd11, P_MA_HIGH = 5'd12, P_WAIT_NEXT = 5'd13,
        P_SP_LOW = 5'd14, P_SP_HIGH = 5'd15, P_SP_REL = 5'd16, P_PAGE_WAIT = 5'd17;
    localparam logic [2:0] S_DEV = 3'd0, S_AHI = 3'd1, S_ALO = 3'd2,
        S_DEVR = 3'd3, S_DATA = 3'd4;

    logic [4:0]  phase_reg, phase_next;
    logic [2:0]  stage_reg, stage_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] naddr_reg, naddr_next;
    logic        open_reg, open_next, rd_reg, rd_next, drop_reg, drop_next;
    logic        hv_reg, hv_next, hr_reg, hr_next, hf_reg, hf_next;
    logic [15:0] ha_reg, ha_next;
    logic [7:0]  hd_reg, hd_next;
    logic [7:0]  ackc_reg, ackc_next;
    logic [23:0] pwc_reg, pwc_next;
    logic        ov_reg;
    iepm_res_t   o_reg, o;
    logic        take, tick, last;
    logic [15:0] inc_addr;
    logic [7:0]  timeout;

    assign q_ready = !ov_reg || res_ready;
    assign take    = q_valid && q_ready;
    assign tick    = take && q_item.is_tick;
    assign res_valid = ov_reg;
    assign res     = o_reg;
    assign timeout = (cfg.ack_ticks == 8'd0) ? 8'd1 : cfg.ack_ticks;

    // phase sequencer
    always_comb
    begin
        phase_next = phase_reg; stage_next = stage_reg; bit_next = bit_reg;
        shift_next = shift_reg; naddr_next = naddr_reg; open_next = open_reg;
        rd_next = rd_reg; drop_next = drop_reg; hv_next = hv_reg; hr_next = hr_reg;
        hf_next = hf_reg; ha_next = ha_reg; hd_next = hd_reg;
        ackc_next = ackc_reg; pwc_next = pwc_reg;
        o = '0;
        inc_addr = ha_reg + 16'd1;
        last = hf_reg || (inc_addr[PAGE_BITS-1:0] == '0);
        if (take && !q_item.is_tick)
        begin
            if (!hv_reg)
            begin
                hv_next = 1'b1; hr_next = q_item.is_read; ha_next = q_item.address;
                hd_next = q_item.data; hf_next = q_item.final_byte;
            end
        end
        else if (tick)
        begin
            if (drop_reg && hv_reg)
            begin
                o.byte_done = 1'b1; o.no_ack_error = 1'b1;
                if (hf_reg) drop_next = 1'b0;
                hv_next = 1'b0;
            end
            unique case (phase_reg) inside
                P_IDLE:
                    if (hv_next)
                    begin
                        open_next = 1'b1; rd_next = hr_reg; naddr_next = ha_reg;
                        shift_next = cfg.two_byte ? DEV_WRITE
                                   : (DEV_WRITE | {4'd0, ha_reg[10:8], 1'b0});
                        stage_next = S_DEV; phase_next = P_ST_FALL;
                    end
                P_ST_FALL: phase_next = P_ST_LOW;
                P_ST_LOW:
                begin
                    bit_next = 4'd0; phase_next = P_TX_SETUP;
                end
                P_RS_PREP: phase_next = P_RS_HIGH;
                P_RS_HIGH: phase_next = P_ST_FALL;
                P_TX_SETUP: phase_next = P_TX_HIGH;
                P_TX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next = bit_reg + 4'd1;
                    if (bit_next >= 4'd8)
                    begin
                        ackc_next = 8'd0; phase_next = P_ACK_SETUP;
                    end
                    else phase_next = P_TX_SETUP;
                end
                P_ACK_SETUP: phase_next = P_ACK_HIGH;
                P_ACK_HIGH:
                    if (!q_item.sda)
                    begin
                        bit_next = 4'd0;
                        unique case (stage_reg) inside
                            S_DEV:
                            begin
                                phase_next = P_TX_SETUP;
                                if (cfg.two_byte)
                                begin
                                    shift_next = ha_reg[15:8]; stage_next = S_AHI;
                                end
                                else
                                begin
                                    shift_next = ha_reg[7:0]; stage_next = S_ALO;
                                end
                            end
                            S_AHI:
                            begin
                                shift_next = ha_reg[7:0]; stage_next = S_ALO;
                                phase_next = P_TX_SETUP;
                            end
                            S_ALO, S_DEVR:
                                if (stage_reg == S_ALO && rd_reg)
                                begin
                                    shift_next = DEV_READ; stage_next = S_DEVR;
                                    phase_next = P_RS_PREP; bit_next = bit_reg;
                                end
                                else
                                begin
                                    stage_next = S_DATA;
                                    shift_next = rd_reg ? 8'd0 : hd_reg;
                                    phase_next = rd_reg ? P_RX_LOW : P_TX_SETUP;
                                end
                            default:
                            begin
                                bit_next = bit_reg;
                                o.byte_done = 1'b1; naddr_next = inc_addr;
                                hv_next = 1'b0;
                                if (last)
                                begin
                                    open_next = 1'b0; phase_next = P_SP_LOW;
                                end
                                else phase_next = P_WAIT_NEXT;
                            end
                        endcase
                    end
                    else
                    begin
                        if (ackc_reg != 8'd255) ackc_next = ackc_reg + 8'd1;
                        if (ackc_next >= timeout)
                        begin
                            o.byte_done = 1'b1; o.no_ack_error = 1'b1;
                            drop_next = hv_next && !hf_reg;
                            hv_next = 1'b0; open_next = 1'b0;
                            phase_next = P_SP_LOW;
                        end
                    end
                P_RX_LOW: phase_next = P_RX_HIGH;
                P_RX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], q_item.sda};
                    bit_next = bit_reg + 4'd1;
                    phase_next = (bit_next >= 4'd8) ? P_MA_SETUP : P_RX_LOW;
                end
                P_MA_SETUP: phase_next = P_MA_HIGH;
                P_MA_HIGH:
                begin
                    o.read_byte = shift_reg; o.read_valid = 1'b1;
                    o.byte_done = 1'b1; naddr_next = inc_addr; hv_next = 1'b0;
                    if (last)
                    begin
                        open_next = 1'b0; phase_next = P_SP_LOW;
                    end
                    else phase_next = P_WAIT_NEXT;
                end
                P_WAIT_NEXT:
                    if (hv_next)
                    begin
                        if (hr_reg == rd_reg && ha_reg == naddr_reg)
                        begin
                            bit_next = 4'd0; stage_next = S_DATA;
                            shift_next = rd_reg ? 8'd0 : hd_reg;
                            phase_next = rd_reg ? P_RX_LOW : P_TX_SETUP;
                        end
                        else
                        begin
                            open_next = 1'b0; phase_next = P_SP_LOW;
                        end
                    end
                P_SP_LOW: phase_next = P_SP_HIGH;
                P_SP_HIGH:
                begin
                    pwc_next = cfg.page_ticks; phase_next = P_SP_REL;
                end
                P_SP_REL, P_PAGE_WAIT:
                    if (pwc_reg == 24'd0) phase_next = P_IDLE;
                    else
                    begin
                        pwc_next = pwc_reg - 24'd1; phase_next = P_PAGE_WAIT;
                    end
                default: phase_next = P_IDLE;
            endcase
            // line drive from the new phase
            unique case (phase_next) inside
                P_ST_FALL:  begin o.scl_level = 1'b1; o.sda_pull_low = 1'b1; end
                P_ST_LOW:   begin o.scl_level = 1'b0; o.sda_pull_low = 1'b1; end
                P_TX_SETUP: begin o.scl_level = 1'b0; o.sda_pull_low = ~shift_next[7]; end
                P_TX_HIGH:  begin o.scl_level = 1'b1; o.sda_pull_low = ~shift_next[7]; end
                P_RS_PREP, P_ACK_SETUP, P_RX_LOW, P_WAIT_NEXT:
                    begin o.scl_level = 1'b0; o.sda_pull_low = 1'b0; end
                P_MA_SETUP: begin o.scl_level = 1'b0; o.sda_pull_low = ~last; end
                P_MA_HIGH:  begin o.scl_level = 1'b1; o.sda_pull_low = ~last; end
                P_SP_LOW:   begin o.scl_level = 1'b0; o.sda_pull_low = 1'b1; end
                P_SP_HIGH:  begin o.scl_level = 1'b1; o.sda_pull_low = 1'b1; end
                default:    begin o.scl_level = 1'b1; o.sda_pull_low = 1'b0; end
            endcase
            o.engine_busy = (phase_next != P_IDLE);
        end
    end

    // engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE; stage_reg <= S_DEV; bit_reg <= 4'd0;
            shift_reg <= 8'd0; naddr_reg <= 16'd0; open_reg <= 1'b0;
            rd_reg <= 1'b0; drop_reg <= 1'b0; hv_reg <= 1'b0; hr_reg <= 1'b0;
            hf_reg <= 1'b0; ha_reg <= 16'd0; hd_reg <= 8'd0;
            ackc_reg <= 8'd0; pwc_reg <= 24'd0; ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; stage_reg <= stage_next; bit_reg <= bit_next;
            shift_reg <= shift_next; naddr_reg <= naddr_next; open_reg <= open_next;
            rd_reg <= rd_next; drop_reg <= drop_next; hv_reg <= hv_next;
            hr_reg <= hr_next; hf_reg <= hf_next; ha_reg <= ha_next;
            hd_reg <= hd_next; ackc_reg <= ackc_next; pwc_reg <= pwc_next;
            if (tick) ov_reg <= 1'b1;
            else if (res_ready) ov_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            o_reg <= o;
        end
    end

endmodule

// File: rtl/core/i2c_eeprom_paged_master.sv
// top level of the paged eeprom i2c master
//
// channel  | dir | handshake               | payload
// s_axis   | in  | s_axis_tvalid/tready    | tuser (cmd), tdata, tlast (final_byte)
// m_axis   | out | m_axis_tvalid/tready    | tdata (line drive and status)
// cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// one word per cycle while the queue has room; every word but an unknown
// command passes a two-entry queue, and the engine registers the result of
// each tick word in its result register, which presents it on m_axis
// the engine does one bus phase per tick word
// reset is asynchronous active low and puts the bus idle with lines released
// a stalled output holds its word; the queue keeps taking words until full
`timescale 1ns / 1ps

module i2c_eeprom_paged_master
    import iepm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // address, write_byte, sda_sample
    input  logic [1:0]  s_axis_tuser,  // cmd
    input  logic        s_axis_tlast,  // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // scl_level, sda_pull_low, read_byte,
                                       // read_valid, byte_done, no_ack_error,
                                       // engine_busy
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    iepm_cfg_t  cfg;
    logic       q_valid, q_ready;
    iepm_item_t q_item;
    iepm_res_t  res;

    iepm_front u_front (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .s_axis_tlast, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg,
        .q_valid, .q_ready, .q_item
    );

    iepm_engine u_engine (
        .clk, .rst_n, .cfg, .q_valid, .q_ready, .q_item,
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
    );

    assign m_axis_tdata = {2'b00, res.engine_busy, res.no_ack_error, res.byte_done,
                           res.read_valid, res.read_byte, res.sda_pull_low,
                           res.scl_level};

`ifndef SYNTHESIS
    // a received byte always completes a request byte
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[11])
        else $error("read without byte done");
    // idle result releases both lines
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("idle with lines driven");
    // ack error only with byte done
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11])
        else $error("error without byte done");
`endif

endmodule
